FILE: src/sitd_pkg.sv
package sitd_pkg;

  // Input word width and magnitude width (the magnitude of the most
  // negative value, 2^31, still fits in 32 unsigned bits).
  localparam int VALUE_W = 32;
  localparam int MAG_W   = 32;
  localparam int STEP_W  = $clog2(MAG_W);

  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Digit adjust threshold and offset of the shift-and-add-3 conversion.
  localparam logic [DIGIT_W-1:0] DD_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_OFFSET = 4'd3;

  localparam int DEFAULT_MAX_DIGITS  = 10;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  // One classified number as it waits between front and back.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } num_entry_t;

  // Queue handshake between the two halves.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: src/sitd_if.sv
interface sitd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sitd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sitd_pkg::CHAR_W-1:0]   text_char;
  logic                          last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: src/signed_int_to_decimal_ascii.sv
// Channel  Dir  Word                         Handshake
// -------  ---  ---------------------------  ----------------
// number   in   value  (32-bit signed)       valid / ready
// text     out  text_char (8), last_char (1)  valid / ready
//
// Each number leaves the queue into the back end, which converts it to BCD by
// bit-serial shift-and-add-3 over all 32 magnitude bits, skips leading zeros,
// then emits a minus sign if negative and one character per digit. The back end
// holds one number at a time and takes the next from the queue only when idle.
// Reset (rst, synchronous) empties the queue and idles the back end; a stalled
// text channel holds the back end while the front fills the queue.
module signed_int_to_decimal_ascii #(
  parameter int MAX_DIGITS  = sitd_pkg::DEFAULT_MAX_DIGITS,
  parameter int QUEUE_DEPTH = sitd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  sitd_in_if.sink     number,
  sitd_out_if.source  text
);

  // Classified numbers on their way from front to back.
  sitd_pkg::num_entry_t    push_entry;
  sitd_pkg::num_entry_t    pop_entry;
  sitd_pkg::queue_status_t status;
  logic                    push;
  logic                    pop;

  // Front: accept a word, split it into sign and magnitude.
  sitd_front u_front (
    .number (number),
    .status (status),
    .push   (push),
    .entry  (push_entry)
  );

  // Short queue: lets the front keep accepting while the back end converts.
  sitd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (status)
  );

  // Back: convert to BCD, strip leading zeros, emit the characters.
  sitd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .entry  (pop_entry),
    .pop    (pop),
    .text   (text)
  );

endmodule

FILE: src/sitd_front.sv
module sitd_front (
  sitd_in_if.sink                 number,
  input  sitd_pkg::queue_status_t status,
  output logic                    push,
  output sitd_pkg::num_entry_t    entry
);

  // Take a word whenever the queue has room.
  assign number.ready = !status.full;
  assign push         = number.valid && !status.full;

  // Classify: sign flag plus magnitude, negated in unsigned 32-bit arithmetic.
  assign entry.neg = number.value[sitd_pkg::VALUE_W-1];
  assign entry.mag = entry.neg ? sitd_pkg::MAG_W'(32'd0 - 32'(number.value))
                               : sitd_pkg::MAG_W'(number.value);

endmodule

FILE: src/sitd_queue.sv
module sitd_queue #(
  parameter int DEPTH = sitd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sitd_pkg::num_entry_t    push_entry,
  input  logic                    pop,
  output sitd_pkg::num_entry_t    pop_entry,
  output sitd_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sitd_pkg::num_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_entry    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: src/sitd_back.sv
module sitd_back #(
  parameter int MAX_DIGITS = sitd_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sitd_pkg::queue_status_t status,
  input  sitd_pkg::num_entry_t    entry,
  output logic                    pop,
  sitd_out_if.source              text
);

  localparam int PTR_W = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    SKIP,
    SIGN,
    EMIT
  } state_t;

  state_t state;

  logic [sitd_pkg::MAG_W-1:0]   bin;
  logic [sitd_pkg::DIGIT_W-1:0] digit     [MAX_DIGITS];
  logic [sitd_pkg::DIGIT_W-1:0] adj       [MAX_DIGITS];
  logic [sitd_pkg::DIGIT_W-1:0] digit_next[MAX_DIGITS];
  logic [sitd_pkg::STEP_W-1:0]  step;
  logic [PTR_W-1:0]             ptr;
  logic                         neg;

  logic                         out_valid;
  logic [sitd_pkg::CHAR_W-1:0]  out_char;
  logic                         out_last;
  logic                         can_emit;
  logic                         load_char;

  assign can_emit       = !out_valid || text.ready;
  assign load_char      = ((state == SIGN) || (state == EMIT)) && can_emit;
  assign pop            = (state == IDLE) && !status.empty;
  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last_char = out_last;

  // One shift-and-add-3 step: adjust each digit, then shift the next bit in.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit[i] >= sitd_pkg::DD_LIMIT) ? digit[i] + sitd_pkg::DD_OFFSET
                                                 : digit[i];
    end
    digit_next[0] = {adj[0][sitd_pkg::DIGIT_W-2:0], bin[sitd_pkg::MAG_W-1]};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      digit_next[i] = {adj[i][sitd_pkg::DIGIT_W-2:0], adj[i-1][sitd_pkg::DIGIT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_char) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!status.empty) begin
            bin   <= entry.mag;
            neg   <= entry.neg;
            step  <= '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
              digit[i] <= '0;
            end
            state <= CONV;
          end
        end
        CONV: begin
          digit <= digit_next;
          bin   <= {bin[sitd_pkg::MAG_W-2:0], 1'b0};
          step  <= step + 1'b1;
          if (step == sitd_pkg::STEP_W'(sitd_pkg::MAG_W - 1)) begin
            ptr   <= PTR_W'(MAX_DIGITS - 1);
            state <= SKIP;
          end
        end
        SKIP: begin
          // Drop leading zeros, but keep the units digit.
          if (digit[ptr] == '0 && ptr != '0) begin
            ptr <= ptr - 1'b1;
          end else begin
            state <= neg ? SIGN : EMIT;
          end
        end
        SIGN: begin
          if (can_emit) begin
            out_char  <= sitd_pkg::CHAR_MINUS;
            out_last  <= 1'b0;
            state     <= EMIT;
          end
        end
        EMIT: begin
          if (can_emit) begin
            out_char  <= sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_W'(digit[ptr]);
            out_last  <= (ptr == '0);
            if (ptr == '0) begin
              state <= IDLE;
            end else begin
              ptr <= ptr - 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
